// File: sv/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/tccw_pkg.sv
package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field and index widths
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int ADDR_W  = 11;
  localparam int COL_W   = $clog2(COLUMNS + 1);
  localparam int ROW_W   = $clog2(ROWS + 1);
  localparam int MIDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Character codes and reset values
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h1F;

  // Configuration register indexes
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  // Control states, one-hot
  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_CLEAR = 3'b010,
    ST_PEND  = 3'b100
  } state_t;

endpackage

// File: sv/text_console_char_writer_top.sv
// The result beat appears in the cycle after its input beat is accepted.
// One character per cycle, except while the output stalls or a fill runs.
// An item that runs past the last row clears the screen store one cell per
// cycle, then writes its own cell unless it is a newline.
// Reset: cursor to 0,0, attribute 0x1F, then the same fill pass writes
// 0x1F20 into every cell; input is stalled during any fill pass.
`include "assert_macros.svh"

module text_console_char_writer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tccw_pkg::CHAR_W-1:0]   in_char_code,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_cell_written,
  output logic [tccw_pkg::ADDR_W-1:0]   out_cell_address,
  output logic [tccw_pkg::CELL_W-1:0]   out_cell_value,
  output logic [tccw_pkg::ADDR_W-1:0]   out_cursor_position,
  output logic                          out_screen_cleared,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int COL_W  = tccw_pkg::COL_W;
  localparam int ROW_W  = tccw_pkg::ROW_W;
  localparam int ADDR_W = tccw_pkg::ADDR_W;
  localparam int CELL_W = tccw_pkg::CELL_W;
  localparam int MIDX_W = tccw_pkg::MIDX_W;

  // Screen store
  logic [CELL_W-1:0] screen_mem [tccw_pkg::CELLS];

  logic [tccw_pkg::ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]            col_r, col_nxt;
  logic [ROW_W-1:0]            row_r, row_nxt;
  tccw_pkg::state_t            state_r, state_nxt;
  logic [MIDX_W-1:0]           clr_idx_r, clr_idx_nxt;
  logic [CELL_W-1:0]           fill_cell_r, fill_cell_nxt;
  logic                        pend_we_r, pend_we_nxt;
  logic [MIDX_W-1:0]           pend_addr_r, pend_addr_nxt;
  logic [CELL_W-1:0]           pend_data_r, pend_data_nxt;
  logic                        out_valid_r;
  logic                        out_written_r;
  logic [ADDR_W-1:0]           out_addr_r;
  logic [CELL_W-1:0]           out_value_r;
  logic [ADDR_W-1:0]           out_pos_r;
  logic                        out_cleared_r;

  logic                        in_accept;
  logic                        out_free;
  logic                        cfg_write;
  logic                        is_newline;
  logic                        wrap;
  logic [COL_W-1:0]            col_a, col_b;
  logic [ROW_W-1:0]            row_a, row_b;
  logic                        clr_needed;
  logic [ADDR_W-1:0]           cell_addr;
  logic [CELL_W-1:0]           cell_value;
  logic [ADDR_W-1:0]           cursor_pos;
  logic                        mem_we;
  logic [MIDX_W-1:0]           mem_addr;
  logic [CELL_W-1:0]           mem_wdata;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == tccw_pkg::REG_TEXT_ATTRIBUTE) begin
      cfg_prdata = {{(32 - tccw_pkg::ATTR_W){1'b0}}, attr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tccw_pkg::ATTR_RESET;
    end else if (cfg_write && cfg_paddr[2] == tccw_pkg::REG_TEXT_ATTRIBUTE) begin
      attr_r <= cfg_pwdata[tccw_pkg::ATTR_W-1:0];
    end
  end

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != tccw_pkg::ST_RUN) || !out_free;
  assign in_accept = in_valid && !in_stall;

  // Cursor update: wrap, then clear check, then newline or character
  assign is_newline = (in_char_code == tccw_pkg::CHAR_NEWLINE);
  assign wrap       = (col_r >= COL_W'(tccw_pkg::COLUMNS));
  assign col_a      = wrap ? '0 : col_r;
  assign row_a      = wrap ? row_r + ROW_W'(1) : row_r;
  assign clr_needed = (row_a >= ROW_W'(tccw_pkg::ROWS));
  assign col_b      = clr_needed ? '0 : col_a;
  assign row_b      = clr_needed ? '0 : row_a;

  always_comb begin
    if (is_newline) begin
      col_nxt = '0;
      row_nxt = row_b + ROW_W'(1);
    end else begin
      col_nxt = col_b + COL_W'(1);
      row_nxt = row_b;
    end
  end

  assign cell_addr  = ADDR_W'(row_b) * ADDR_W'(tccw_pkg::COLUMNS) + ADDR_W'(col_b);
  assign cell_value = {attr_r, in_char_code};
  assign cursor_pos = ADDR_W'(row_nxt) * ADDR_W'(tccw_pkg::COLUMNS) + ADDR_W'(col_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Fill sequencer: sweep all cells, then apply the held character write
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    fill_cell_nxt = fill_cell_r;
    pend_we_nxt   = pend_we_r;
    pend_addr_nxt = pend_addr_r;
    pend_data_nxt = pend_data_r;
    mem_we        = 1'b0;
    mem_addr      = clr_idx_r;
    mem_wdata     = fill_cell_r;
    unique case (state_r)
      tccw_pkg::ST_RUN: begin
        if (in_accept && clr_needed) begin
          state_nxt     = tccw_pkg::ST_CLEAR;
          clr_idx_nxt   = '0;
          fill_cell_nxt = {attr_r, tccw_pkg::CHAR_SPACE};
          pend_we_nxt   = !is_newline;
          pend_addr_nxt = cell_addr[MIDX_W-1:0];
          pend_data_nxt = cell_value;
        end else if (in_accept && !is_newline) begin
          mem_we    = 1'b1;
          mem_addr  = cell_addr[MIDX_W-1:0];
          mem_wdata = cell_value;
        end
      end
      tccw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx_r == MIDX_W'(tccw_pkg::CELLS - 1)) begin
          state_nxt = tccw_pkg::ST_PEND;
        end else begin
          clr_idx_nxt = clr_idx_r + MIDX_W'(1);
        end
      end
      tccw_pkg::ST_PEND: begin
        mem_we    = pend_we_r;
        mem_addr  = pend_addr_r;
        mem_wdata = pend_data_r;
        state_nxt = tccw_pkg::ST_RUN;
      end
      default: begin
        state_nxt = tccw_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tccw_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      fill_cell_r <= {tccw_pkg::ATTR_RESET, tccw_pkg::CHAR_SPACE};
      pend_we_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      fill_cell_r <= fill_cell_nxt;
      pend_we_r   <= pend_we_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_addr] <= mem_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_written_r <= !is_newline;
      out_addr_r    <= is_newline ? '0 : cell_addr;
      out_value_r   <= is_newline ? '0 : cell_value;
      out_pos_r     <= cursor_pos;
      out_cleared_r <= clr_needed;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cell_written    = out_written_r;
  assign out_cell_address    = out_addr_r;
  assign out_cell_value      = out_value_r;
  assign out_cursor_position = out_pos_r;
  assign out_screen_cleared  = out_cleared_r;

  // Checks
  `ASSERT_NEXT(a_clear_starts, clk, rst_n, in_accept && clr_needed,
               state_r == tccw_pkg::ST_CLEAR && clr_idx_r == '0)
  `ASSERT_ALWAYS(a_no_accept_in_fill, clk, rst_n,
                 !(in_valid && !in_stall) || state_r == tccw_pkg::ST_RUN)
  `ASSERT_ALWAYS(a_cursor_in_range, clk, rst_n,
                 row_r <= ROW_W'(tccw_pkg::ROWS) && col_r <= COL_W'(tccw_pkg::COLUMNS))
  `ASSERT_NEXT(a_pend_follows_sweep, clk, rst_n,
               state_r == tccw_pkg::ST_CLEAR && clr_idx_r == MIDX_W'(tccw_pkg::CELLS - 1),
               state_r == tccw_pkg::ST_PEND)

endmodule

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry, widths and codes of the block
  localparam int ADDR_W  = tccw_pkg::ADDR_W;
  localparam int CELL_W  = tccw_pkg::CELL_W;
  localparam int CHAR_W  = tccw_pkg::CHAR_W;
  localparam int ATTR_W  = tccw_pkg::ATTR_W;
  localparam int COL_W   = tccw_pkg::COL_W;
  localparam int ROW_W   = tccw_pkg::ROW_W;
  localparam int CELLS   = tccw_pkg::CELLS;
  localparam int COLUMNS = tccw_pkg::COLUMNS;
  localparam int ROWS    = tccw_pkg::ROWS;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = tccw_pkg::CHAR_NEWLINE;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = tccw_pkg::CHAR_SPACE;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = tccw_pkg::ATTR_RESET;
  localparam logic REG_TEXT_ATTRIBUTE = tccw_pkg::REG_TEXT_ATTRIBUTE;

  // Byte addresses of the configuration registers
  localparam logic [2:0] ATTR_ADDR  = 3'(4 * int'(REG_TEXT_ATTRIBUTE));
  localparam logic [2:0] SPARE_ADDR = 3'(4 * (int'(REG_TEXT_ATTRIBUTE) + 1));
  localparam int PHASE_ITEMS = 400;

  // One result beat as the block reports it
  typedef struct packed {
    logic              written;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] value;
    logic [ADDR_W-1:0] pos;
    logic              cleared;
  } cell_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CHAR_W-1:0]   in_char_code = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_cell_written;
  logic [ADDR_W-1:0]   out_cell_address;
  logic [CELL_W-1:0]   out_cell_value;
  logic [ADDR_W-1:0]   out_cursor_position;
  logic                out_screen_cleared;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [2:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // Shadow of the console state
  logic [ATTR_W-1:0]   text_attr;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [CELL_W-1:0]   shadow_screen [CELLS];

  cell_beat_t          cells_due [$];
  int                  gap_pct = 0;
  int                  stall_pct = 0;
  int                  fail_count = 0;
  int                  items_sent = 0;
  int                  n_newlines = 0;
  int                  n_wraps = 0;
  int                  n_clears = 0;

  text_console_char_writer_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_code        (in_char_code),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cell_written    (out_cell_written),
    .out_cell_address    (out_cell_address),
    .out_cell_value      (out_cell_value),
    .out_cursor_position (out_cursor_position),
    .out_screen_cleared  (out_screen_cleared),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Count a failure, report only the first few
  task automatic flag(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      flag($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    end
  endtask

  // Wipe the shadow screen with spaces in the given colour
  function automatic void fill_shadow(logic [ATTR_W-1:0] attr);
    for (int i = 0; i < CELLS; i++) begin
      shadow_screen[i] = {attr, CHAR_SPACE};
    end
  endfunction

  // Print one character into the shadow console and return the beat it causes
  function automatic cell_beat_t print_char(logic [CHAR_W-1:0] ch);
    cell_beat_t beat;
    int lin;
    beat = '0;
    // wrap a full line first
    if (int'(cur_col) >= COLUMNS) begin
      cur_col = '0;
      cur_row = cur_row + 1'b1;
      n_wraps++;
    end
    // ran off the bottom: clear and home
    if (int'(cur_row) >= ROWS) begin
      fill_shadow(text_attr);
      cur_col = '0;
      cur_row = '0;
      beat.cleared = 1'b1;
      n_clears++;
    end
    if (ch == CHAR_NEWLINE) begin
      cur_col = '0;
      cur_row = cur_row + 1'b1;
      n_newlines++;
    end else begin
      lin = int'(cur_row) * COLUMNS + int'(cur_col);
      beat.addr = lin[ADDR_W-1:0];
      beat.value = {text_attr, ch};
      if (lin < CELLS) begin
        shadow_screen[lin] = beat.value;
      end
      beat.written = 1'b1;
      cur_col = cur_col + 1'b1;
    end
    lin = int'(cur_row) * COLUMNS + int'(cur_col);
    beat.pos = lin[ADDR_W-1:0];
    return beat;
  endfunction

  // Compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_beats
    cell_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cells_due.size() == 0) begin
        flag("result beat with nothing expected");
      end else begin
        want = cells_due.pop_front();
        check_field("cell_written", 32'(want.written), 32'(out_cell_written));
        check_field("cell_address", 32'(want.addr), 32'(out_cell_address));
        check_field("cell_value", 32'(want.value), 32'(out_cell_value));
        check_field("cursor_position", 32'(want.pos), 32'(out_cursor_position));
        check_field("screen_cleared", 32'(want.cleared), 32'(out_screen_cleared));
      end
    end
  end

  // Send one character beat, idling first at the current gap rate
  task automatic send_char(logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cells_due.push_back(print_char(ch));
    items_sent++;
  endtask

  // Drop valid and wait until every prediction has been matched
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ATTR_ADDR) begin
      text_attr = data[ATTR_W-1:0];
    end
    @(posedge clk);
  endtask

  // APB read of the attribute register, checked against the shadow copy
  task automatic cfg_check_attr();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= ATTR_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field("text_attribute readback", 32'(text_attr), cfg_prdata);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Extreme and sign-sensitive bytes, controls and a newline
  task automatic test_char_extremes();
    logic [CHAR_W-1:0] codes [8];
    codes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h09, CHAR_NEWLINE, 8'h55, 8'hAA};
    foreach (codes[i]) send_char(codes[i]);
    wait_idle();
  endtask

  // Attribute at both extremes; a write past the last register is dropped
  task automatic test_attribute_extremes();
    cfg_write(ATTR_ADDR, 32'hFFFF_FF00);
    cfg_check_attr();
    send_char(8'h41);
    wait_idle();
    cfg_write(ATTR_ADDR, 32'h0000_00FF);
    cfg_check_attr();
    send_char(8'hFE);
    wait_idle();
    cfg_write(SPARE_ADDR, 32'h0000_005A);
    cfg_check_attr();
    send_char(8'h42);
    wait_idle();
  endtask

  // Newlines down to past the last row, then the next beat clears the screen
  task automatic test_clear_on_last_row();
    while (int'(cur_row) < ROWS) send_char(CHAR_NEWLINE);
    send_char(8'h43);
    send_char(CHAR_NEWLINE);
    wait_idle();
  endtask

  // Random lines of text: mostly well formed, some noise and missing newlines
  task automatic test_random_text(int gap, int stall, logic [ATTR_W-1:0] attr);
    logic [31:0]       wdata;
    logic [CHAR_W-1:0] ch;
    int                kind;
    int                len;
    int                target;
    wdata = $urandom();
    wdata[ATTR_W-1:0] = attr;
    cfg_write(ATTR_ADDR, wdata);
    cfg_check_attr();
    gap_pct = gap;
    stall_pct = stall;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        // burst of blank lines, pushes toward the bottom quickly
        repeat ($urandom_range(30, 1)) send_char(CHAR_NEWLINE);
      end else begin
        if (kind < 60) len = $urandom_range(15);
        else if (kind < 85) len = $urandom_range(79, 16);
        else len = $urandom_range(200, 80);
        repeat (len) begin
          ch = CHAR_W'($urandom_range(255));
          while (ch == CHAR_NEWLINE && $urandom_range(99) < 90) begin
            ch = CHAR_W'($urandom_range(255));
          end
          send_char(ch);
        end
        if ($urandom_range(99) < 90) send_char(CHAR_NEWLINE);
      end
    end
    wait_idle();
    gap_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    text_attr = ATTR_RESET;
    cur_col = '0;
    cur_row = '0;
    fill_shadow(ATTR_RESET);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the power-up fill pass releases the input
    @(posedge clk);
    while (in_stall) @(posedge clk);

    cfg_check_attr();
    test_char_extremes();
    test_attribute_extremes();
    test_clear_on_last_row();
    test_random_text(0, 0, 8'($urandom_range(255)));
    test_random_text(57, 0, 8'hFF);
    test_random_text(0, 57, 8'h00);
    test_random_text(23, 23, 8'($urandom_range(255)));

    repeat (20) @(posedge clk);
    if (cells_due.size() != 0) begin
      flag($sformatf("%0d result beats never arrived", cells_due.size()));
    end
    $display("Run covered %0d characters: %0d newlines, %0d line wraps, %0d screen clears.",
             items_sent, n_newlines, n_wraps, n_clears);
    $display("Attributes 0x00, 0xFF, reset and random; gaps and stalls up to 57 percent.");
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
